// ===== src/ptt_pkg.sv =====
// Shared types and constants for the periodic timer table.
package ptt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int SLOT_W     = 4;
    localparam int SEL_W      = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int TAG_W      = 32;
    localparam int IVAL_W     = 32;
    localparam int ELAP_W     = 33;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 2;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 40;

    localparam logic [OP_W-1:0] OP_REG   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNREG = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE  = 2'd2;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SEL_W-1:0]  t_sel;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

    // Command broadcast to every slot cell.
    typedef struct packed {
        logic              wr;
        logic              unreg;
        logic              tick;
        logic              shift;
        logic [SLOT_W-1:0] slot;
        logic [IVAL_W-1:0] interval;
        logic              one_shot;
        logic [TAG_W-1:0]  tag;
    } t_cell_ctl;

    // Fire record handed from one cell to the next one down the chain.
    typedef struct packed {
        logic             v;
        logic [TAG_W-1:0] tag;
    } t_chain;

endpackage

// ===== src/ptt_cell.sv =====
// One timer slot: its state, its tick update and one stage of the fire chain.
module ptt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptt_pkg::t_idx      i_idx,
    input  ptt_pkg::t_cell_ctl i_ctl,
    input  ptt_pkg::t_chain    i_nxt,
    output ptt_pkg::t_chain    o_chain,
    output logic               o_hit
);

    logic                          r_armed;
    logic                          r_single;
    logic [ptt_pkg::IVAL_W-1:0]    r_period;
    logic [ptt_pkg::ELAP_W-1:0]    r_elapsed;
    logic [ptt_pkg::TAG_W-1:0]     r_tag;
    logic                          r_sh_v;
    logic [ptt_pkg::TAG_W-1:0]     r_sh_tag;

    logic                          sel;
    logic                          due;
    logic [ptt_pkg::ELAP_W-1:0]    elapsed_inc;

    assign sel = (ptt_pkg::t_sel'(i_ctl.slot) == ptt_pkg::t_sel'(i_idx));
    assign due = r_armed && (r_elapsed >= {1'b0, r_period});
    // The count cannot pass the interval, but it saturates all the same.
    assign elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;

    assign o_hit   = r_armed && sel;
    assign o_chain = '{v: r_sh_v, tag: r_sh_tag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_sh_v  <= 1'b0;
        end else begin
            if (i_ctl.wr && sel) begin
                r_armed <= 1'b1;
            end else if (i_ctl.unreg && sel) begin
                r_armed <= 1'b0;
            end else if (i_ctl.tick && due && r_single) begin
                r_armed <= 1'b0;
            end
            if (i_ctl.tick) begin
                r_sh_v <= due;
            end else if (i_ctl.shift) begin
                r_sh_v <= i_nxt.v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && sel) begin
            r_single  <= i_ctl.one_shot;
            r_period  <= (i_ctl.interval == '0) ? ptt_pkg::IVAL_W'(1) : i_ctl.interval;
            r_elapsed <= '0;
            r_tag     <= i_ctl.tag;
        end else if (i_ctl.tick && r_armed) begin
            // A periodic slot that fires restarts from zero and counts this tick.
            r_elapsed <= due ? ptt_pkg::ELAP_W'(1) : elapsed_inc;
        end
        if (i_ctl.tick) begin
            r_sh_tag <= r_tag;
        end else if (i_ctl.shift) begin
            r_sh_tag <= i_nxt.tag;
        end
    end

endmodule

// ===== src/periodic_timer_table.sv =====
// Register and query answers are registered and appear in the cycle after the
// transaction. A tick updates every slot in its accept cycle, then shifts the fire
// chain one slot per cycle while the result side does not stall, and releases the
// final fire from the flush state. Register, unregister and query are taken one per
// cycle while the output is free; a tick holds the input off until its walk and flush end.
// Reset (synchronous, active low) frees every slot and empties the output.
module periodic_timer_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata fields from bit 0: slot(4), interval(32), one_shot(1), tag(32), zero(3)
    input  logic [ptt_pkg::S_DATA_W-1:0]   i_s_tdata,
    // tuser: opcode(2)
    input  logic [ptt_pkg::OP_W-1:0]       i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata fields from bit 0: out_slot(4), out_tag(32), exists(1), zero(3)
    output logic [ptt_pkg::M_DATA_W-1:0]   o_m_tdata,
    // tuser: kind(2)
    output logic [ptt_pkg::KIND_W-1:0]     o_m_tuser,
    output logic                           o_m_tlast
);

    ptt_pkg::t_state               r_state;
    ptt_pkg::t_state               n_state;
    ptt_pkg::t_cnt                 r_cnt;

    logic                          r_held_v;
    ptt_pkg::t_slot                r_held_slot;
    logic [ptt_pkg::TAG_W-1:0]     r_held_tag;

    logic                          r_m_tvalid;
    logic [ptt_pkg::KIND_W-1:0]    r_kind;
    ptt_pkg::t_slot                r_slot;
    logic [ptt_pkg::TAG_W-1:0]     r_tag;
    logic                          r_exists;
    logic                          r_last;

    logic [ptt_pkg::KIND_W-1:0]    n_kind;
    ptt_pkg::t_slot                n_slot;
    logic [ptt_pkg::TAG_W-1:0]     n_tag;
    logic                          n_exists;
    logic                          n_last;

    ptt_pkg::t_cell_ctl            ctl;
    ptt_pkg::t_chain               chain [ptt_pkg::NUM_TIMERS];
    logic [ptt_pkg::NUM_TIMERS-1:0] hit;

    logic                          out_free;
    logic                          accept;
    logic                          advance;
    logic                          ld_out;
    logic                          held_ld;
    logic                          held_clr;
    logic                          s_ready;

    assign out_free = !r_m_tvalid || i_m_tready;
    assign accept   = i_s_tvalid && s_ready;
    // The walk pauses only when a fire has to leave and the output is still full.
    assign advance  = !(chain[0].v && r_held_v) || out_free;

    genvar g;
    generate
        for (g = 0; g < ptt_pkg::NUM_TIMERS; g++) begin : g_cell
            ptt_pkg::t_chain nxt;
            if (g == ptt_pkg::NUM_TIMERS - 1) begin : g_end
                assign nxt = '0;
            end else begin : g_mid
                assign nxt = chain[g+1];
            end
            ptt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (ptt_pkg::t_idx'(g)),
                .i_ctl   (ctl),
                .i_nxt   (nxt),
                .o_chain (chain[g]),
                .o_hit   (hit[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            ptt_pkg::ST_IDLE: begin
                if (accept && i_s_tuser == ptt_pkg::OP_TICK) begin
                    n_state = ptt_pkg::ST_WALK;
                end
            end
            ptt_pkg::ST_WALK: begin
                if (advance && r_cnt == ptt_pkg::t_cnt'(ptt_pkg::NUM_TIMERS - 1)) begin
                    n_state = ptt_pkg::ST_FLUSH;
                end
            end
            ptt_pkg::ST_FLUSH: begin
                if (!r_held_v || out_free) begin
                    n_state = ptt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        ctl.wr       = 1'b0;
        ctl.unreg    = 1'b0;
        ctl.tick     = 1'b0;
        ctl.shift    = 1'b0;
        ctl.slot     = i_s_tdata[3:0];
        ctl.interval = i_s_tdata[35:4];
        ctl.one_shot = i_s_tdata[36];
        ctl.tag      = i_s_tdata[68:37];
        ld_out       = 1'b0;
        held_ld      = 1'b0;
        held_clr     = 1'b0;
        n_kind       = r_kind;
        n_slot       = r_slot;
        n_tag        = r_tag;
        n_exists     = r_exists;
        n_last       = r_last;
        case (r_state)
            ptt_pkg::ST_IDLE: begin
                s_ready = out_free;
                if (accept) begin
                    case (i_s_tuser)
                        ptt_pkg::OP_REG: begin
                            ctl.wr   = 1'b1;
                            ld_out   = 1'b1;
                            n_kind   = ptt_pkg::KIND_ACK;
                            n_slot   = i_s_tdata[3:0];
                            n_tag    = '0;
                            n_exists = 1'b0;
                            n_last   = 1'b1;
                        end
                        ptt_pkg::OP_UNREG: begin
                            ctl.unreg = 1'b1;
                        end
                        ptt_pkg::OP_TICK: begin
                            ctl.tick = 1'b1;
                        end
                        ptt_pkg::OP_QUERY: begin
                            ld_out   = 1'b1;
                            n_kind   = ptt_pkg::KIND_QUERY;
                            n_slot   = i_s_tdata[3:0];
                            n_tag    = '0;
                            n_exists = |hit;
                            n_last   = 1'b1;
                        end
                        default: begin
                            ld_out = 1'b0;
                        end
                    endcase
                end
            end
            ptt_pkg::ST_WALK: begin
                // A fire is held back one step so that the last one can be marked.
                if (advance) begin
                    ctl.shift = 1'b1;
                    if (chain[0].v) begin
                        held_ld = 1'b1;
                        if (r_held_v) begin
                            ld_out   = 1'b1;
                            n_kind   = ptt_pkg::KIND_FIRE;
                            n_slot   = r_held_slot;
                            n_tag    = r_held_tag;
                            n_exists = 1'b0;
                            n_last   = 1'b0;
                        end
                    end
                end
            end
            ptt_pkg::ST_FLUSH: begin
                if (r_held_v && out_free) begin
                    ld_out   = 1'b1;
                    held_clr = 1'b1;
                    n_kind   = ptt_pkg::KIND_FIRE;
                    n_slot   = r_held_slot;
                    n_tag    = r_held_tag;
                    n_exists = 1'b0;
                    n_last   = 1'b1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ptt_pkg::ST_IDLE;
            r_cnt      <= '0;
            r_held_v   <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ptt_pkg::ST_IDLE) begin
                r_cnt <= '0;
            end else if (ctl.shift) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (held_ld) begin
                r_held_v <= 1'b1;
            end else if (held_clr) begin
                r_held_v <= 1'b0;
            end
            if (ld_out) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (held_ld) begin
            r_held_slot <= ptt_pkg::t_slot'(r_cnt);
            r_held_tag  <= chain[0].tag;
        end
        if (ld_out) begin
            r_kind   <= n_kind;
            r_slot   <= n_slot;
            r_tag    <= n_tag;
            r_exists <= n_exists;
            r_last   <= n_last;
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {3'b000, r_exists, r_tag, r_slot};
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> r_state == ptt_pkg::ST_IDLE)
        else $error("input ready outside the idle state");

    a_tick_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == ptt_pkg::OP_TICK)
        |=> r_state == ptt_pkg::ST_WALK)
        else $error("tick did not start a slot walk");

    a_fire_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ptt_pkg::KIND_FIRE) |-> !o_m_tdata[36])
        else $error("fire result carries an exists flag");

    a_ack_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ptt_pkg::KIND_FIRE) |-> o_m_tdata[35:4] == '0)
        else $error("non-fire result carries a tag");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ptt_pkg::ST_WALK |-> r_cnt < ptt_pkg::t_cnt'(ptt_pkg::NUM_TIMERS))
        else $error("walk counter ran past the table");

endmodule
